FILE: hdl/ist_pkg.sv
`timescale 1ns / 1ps
// ist_pkg: shared widths, function and status codes and the entry layout
// for the integer set table. No dependencies.
package ist_pkg;

    localparam int CAPACITY_DEF = 16;

    localparam int VALUE_W  = 32;
    localparam int INDEX_W  = 4;
    localparam int FUNC_W   = 3;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 4;
    localparam int M_TDATA_W = 48;

    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT     = 3'd0,
        FN_DELETE     = 3'd1,
        FN_LOOKUP     = 3'd2,
        FN_UNION      = 3'd3,
        FN_INTERSECT  = 3'd4,
        FN_DIFFERENCE = 3'd5,
        FN_READ       = 3'd6
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    // one table word: match mark above the stored value
    typedef struct packed {
        logic               mark;
        logic [VALUE_W-1:0] value;
    } entry_t;

endpackage

FILE: hdl/integer_set_table.sv
`timescale 1ns / 1ps
// integer_set_table: ordered table of signed 32-bit values with insert, delete,
// lookup, read by index and streamed union / intersection / difference.
// Depends on ist_pkg.
//
//  channel | direction | contents
//  --------+-----------+-------------------------------------------------------
//  s_      | in        | tdata: value[31:0] index[35:32]; tuser: func[2:0]
//          |           | has_value[3]; tlast: last of the other set
//  m_      | out       | tdata: found[0] read_value[32:1] count[37:33]
//          |           | empty_res[38] status[40:39]
//
// One transaction at a time. Insert, read and no-op do not walk the table; lookup,
// union, delete and marking walk it through the single read port, as does the
// compaction on the last intersection or difference item. The final intersection
// item also checks each kept entry against those already kept.
// Reset is synchronous and clears the count; the table memory is not cleared.
// A result waiting on m_tready holds the next transaction at its last cycle.
module integer_set_table #(
    parameter int CAPACITY = ist_pkg::CAPACITY_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ist_pkg::S_TDATA_W-1:0] s_tdata,   // value, index
    input  logic [ist_pkg::S_TUSER_W-1:0] s_tuser,   // func, has_value
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ist_pkg::M_TDATA_W-1:0] m_tdata    // found, read_value, count, empty_res, status
);
    import ist_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > INDEX_W) ? CW : INDEX_W;

    typedef enum logic [2:0] {
        S_IDLE, S_RD, S_CHK, S_DRD, S_DCHK, S_RFETCH, S_DONE
    } state_t;

    typedef enum logic [1:0] {
        MD_FIND, MD_MARK, MD_DEL, MD_APPLY
    } mode_t;

    entry_t mem [CAPACITY];
    entry_t rdata_reg;

    state_t               state_reg;
    mode_t                mode_reg;
    func_t                func_reg;
    logic [VALUE_W-1:0]   value_reg;
    logic                 last_reg;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        i_reg;
    logic [CW-1:0]        n_reg;
    logic [CW-1:0]        j_reg;
    logic [VALUE_W-1:0]   cand_reg;
    logic                 found_reg;
    logic [VALUE_W-1:0]   rval_reg;
    status_t              status_reg;
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logic [VALUE_W-1:0] in_value;
    logic [INDEX_W-1:0] in_index;
    func_t              in_func;
    logic               in_has_value;
    logic               accept;
    logic               full;
    logic               idx_ok;
    logic               match;
    logic               dedup;
    logic               keep;

    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    entry_t             wr_data;

    assign in_value     = s_tdata[VALUE_W-1:0];
    assign in_index     = s_tdata[VALUE_W +: INDEX_W];
    assign in_func      = func_t'(s_tuser[FUNC_W-1:0]);
    assign in_has_value = s_tuser[FUNC_W];

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign full     = (count_reg == CW'(CAPACITY));
    assign idx_ok   = (XW'(in_index) < XW'(count_reg));
    assign match    = (rdata_reg.value == value_reg);
    // intersection keeps marked entries and drops repeats, difference keeps unmarked
    assign dedup    = (func_reg == FN_INTERSECT);
    assign keep     = (rdata_reg.mark == dedup);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // memory port control
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = i_reg[AW-1:0];
        wr_en   = 1'b0;
        wr_addr = i_reg[AW-1:0];
        wr_data = '{mark: 1'b0, value: value_reg};
        case (state_reg)
            S_IDLE: begin
                if (accept && in_func == FN_INSERT && !full) begin
                    wr_en   = 1'b1;
                    wr_addr = count_reg[AW-1:0];
                    wr_data = '{mark: 1'b0, value: in_value};
                end
                if (accept && in_func == FN_READ) begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(in_index);
                end
            end
            S_RD: begin
                if (i_reg < count_reg) begin
                    rd_en = 1'b1;
                end else if (mode_reg == MD_FIND && func_reg == FN_UNION && !full) begin
                    wr_en   = 1'b1;
                    wr_addr = count_reg[AW-1:0];
                end
            end
            S_CHK: begin
                case (mode_reg)
                    MD_MARK: begin
                        wr_en   = match;
                        wr_data = '{mark: 1'b1, value: value_reg};
                    end
                    MD_DEL: begin
                        wr_en   = !match;
                        wr_addr = n_reg[AW-1:0];
                        wr_data = rdata_reg;
                    end
                    MD_APPLY: begin
                        wr_en   = keep && !dedup;
                        wr_addr = n_reg[AW-1:0];
                        wr_data = '{mark: 1'b0, value: rdata_reg.value};
                    end
                    default: ;
                endcase
            end
            S_DRD: begin
                if (j_reg < n_reg) begin
                    rd_en   = 1'b1;
                    rd_addr = j_reg[AW-1:0];
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = n_reg[AW-1:0];
                    wr_data = '{mark: 1'b0, value: cand_reg};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        func_reg   <= in_func;
                        value_reg  <= in_value;
                        last_reg   <= s_tlast;
                        found_reg  <= 1'b0;
                        rval_reg   <= '0;
                        status_reg <= ST_OK;
                        i_reg      <= '0;
                        n_reg      <= '0;
                        state_reg  <= S_DONE;
                        case (in_func)
                            FN_INSERT: begin
                                if (full) begin
                                    status_reg <= ST_FULL;
                                end else begin
                                    count_reg <= count_reg + CW'(1);
                                end
                            end
                            FN_DELETE: begin
                                mode_reg  <= MD_DEL;
                                state_reg <= S_RD;
                            end
                            FN_LOOKUP: begin
                                mode_reg  <= MD_FIND;
                                state_reg <= S_RD;
                            end
                            FN_UNION: begin
                                if (in_has_value) begin
                                    mode_reg  <= MD_FIND;
                                    state_reg <= S_RD;
                                end
                            end
                            FN_INTERSECT, FN_DIFFERENCE: begin
                                if (in_has_value) begin
                                    mode_reg  <= MD_MARK;
                                    state_reg <= S_RD;
                                end else if (s_tlast) begin
                                    mode_reg  <= MD_APPLY;
                                    state_reg <= S_RD;
                                end
                            end
                            FN_READ: begin
                                if (idx_ok) begin
                                    found_reg <= 1'b1;
                                    state_reg <= S_RFETCH;
                                end else begin
                                    status_reg <= ST_RANGE;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_RD: begin
                    if (i_reg < count_reg) begin
                        state_reg <= S_CHK;
                    end else begin
                        state_reg <= S_DONE;
                        case (mode_reg)
                            MD_FIND: begin
                                // scan ended without a hit
                                if (func_reg == FN_UNION) begin
                                    if (full) begin
                                        status_reg <= ST_FULL;
                                    end else begin
                                        count_reg <= count_reg + CW'(1);
                                    end
                                end
                            end
                            MD_MARK: begin
                                if (last_reg) begin
                                    mode_reg  <= MD_APPLY;
                                    i_reg     <= '0;
                                    n_reg     <= '0;
                                    state_reg <= S_RD;
                                end
                            end
                            default: begin
                                count_reg <= n_reg;
                            end
                        endcase
                    end
                end
                S_CHK: begin
                    i_reg     <= i_reg + CW'(1);
                    state_reg <= S_RD;
                    case (mode_reg)
                        MD_FIND: begin
                            if (match) begin
                                found_reg <= (func_reg == FN_LOOKUP);
                                state_reg <= S_DONE;
                            end
                        end
                        MD_DEL: begin
                            if (!match) begin
                                n_reg <= n_reg + CW'(1);
                            end
                        end
                        MD_APPLY: begin
                            if (keep && dedup) begin
                                // hold the candidate and compare it with kept entries
                                i_reg     <= i_reg;
                                cand_reg  <= rdata_reg.value;
                                j_reg     <= '0;
                                state_reg <= S_DRD;
                            end else if (keep) begin
                                n_reg <= n_reg + CW'(1);
                            end
                        end
                        default: ;
                    endcase
                end
                S_DRD: begin
                    if (j_reg < n_reg) begin
                        state_reg <= S_DCHK;
                    end else begin
                        n_reg     <= n_reg + CW'(1);
                        i_reg     <= i_reg + CW'(1);
                        state_reg <= S_RD;
                    end
                end
                S_DCHK: begin
                    if (rdata_reg.value == cand_reg) begin
                        i_reg     <= i_reg + CW'(1);
                        state_reg <= S_RD;
                    end else begin
                        j_reg     <= j_reg + CW'(1);
                        state_reg <= S_DRD;
                    end
                end
                S_RFETCH: begin
                    rval_reg  <= rdata_reg.value;
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tdata_reg  <= {7'b0, status_reg, (count_reg == '0),
                                         COUNT_W'(count_reg), rval_reg, found_reg};
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: dv/integer_set_table_test.sv
`timescale 1ns / 1ps
// integer_set_table_test: self-checking bench for the integer set table.
// Drives the s_ stream with directed and random commands, predicts each reply from
// its own copy of the table, and compares every m_ transaction. Depends on ist_pkg.
module integer_set_table_test;
    import ist_pkg::*;

    localparam int TABLE_DEPTH = CAPACITY_DEF;
    localparam logic [FUNC_W-1:0] FN_NOP = 3'd7;   // unused code, no operation
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int SETTLE_CYCLES = 600;             // covers a full intersection pass

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [VALUE_W-1:0] value;
        logic [INDEX_W-1:0] index;
        logic               has_value;
        logic               last;
    } set_cmd_t;

    typedef struct packed {
        logic                found;
        logic [VALUE_W-1:0]  read_value;
        logic [COUNT_W-1:0]  count;
        logic                empty_res;
        logic [STATUS_W-1:0] status;
    } set_reply_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // value[31:0], index[35:32], zero fill
    logic [S_TUSER_W-1:0] s_tuser;   // func[2:0], has_value[3]
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // found[0], read_value[32:1], count[37:33],
                                     // empty_res[38], status[40:39], zero fill

    // table copy kept by the predictor
    logic [VALUE_W-1:0] tbl_value [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] tbl_mark;
    int tbl_count;

    set_reply_t pending_replies[$];
    int err_count;
    int cycle_count;
    int rx_hold_left;
    int rx_wait_left;
    bit tx_no_idle;
    bit rx_no_idle;

    integer_set_table #(
        .CAPACITY(TABLE_DEPTH)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // ---------------- predictor ----------------

    function automatic bit tbl_contains(logic [VALUE_W-1:0] v);
        int i;
        for (i = 0; i < tbl_count; i++)
            if (tbl_value[i] == v)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic logic [STATUS_W-1:0] tbl_append(logic [VALUE_W-1:0] v);
        if (tbl_count >= TABLE_DEPTH)
            return ST_FULL;
        tbl_value[tbl_count] = v;
        tbl_mark[tbl_count] = 1'b0;
        tbl_count++;
        return ST_OK;
    endfunction

    function automatic void tbl_mark_value(logic [VALUE_W-1:0] v);
        int i;
        for (i = 0; i < tbl_count; i++)
            if (tbl_value[i] == v)
                tbl_mark[i] = 1'b1;
    endfunction

    // keep entries whose mark equals keep_mark, optionally only the first copy
    function automatic void apply_match_marks(logic keep_mark, bit drop_repeats);
        int i;
        int k;
        int n;
        bit keep;
        n = 0;
        for (i = 0; i < tbl_count; i++) begin
            keep = (tbl_mark[i] == keep_mark);
            if (keep && drop_repeats)
                for (k = 0; k < n; k++)
                    if (tbl_value[k] == tbl_value[i])
                        keep = 1'b0;
            if (keep) begin
                tbl_value[n] = tbl_value[i];
                n++;
            end
        end
        tbl_count = n;
        tbl_mark = '0;
    endfunction

    function automatic set_reply_t predict_table_step(set_cmd_t cmd);
        set_reply_t r;
        int i;
        int n;
        r = '0;
        case (cmd.func)
            FN_INSERT: r.status = tbl_append(cmd.value);
            FN_DELETE: begin
                n = 0;
                for (i = 0; i < tbl_count; i++) begin
                    if (tbl_value[i] != cmd.value) begin
                        tbl_value[n] = tbl_value[i];
                        tbl_mark[n] = tbl_mark[i];
                        n++;
                    end
                end
                tbl_count = n;
            end
            FN_LOOKUP: r.found = tbl_contains(cmd.value);
            FN_UNION: begin
                if (cmd.has_value && !tbl_contains(cmd.value))
                    r.status = tbl_append(cmd.value);
            end
            FN_INTERSECT: begin
                if (cmd.has_value)
                    tbl_mark_value(cmd.value);
                if (cmd.last)
                    apply_match_marks(1'b1, 1'b1);
            end
            FN_DIFFERENCE: begin
                if (cmd.has_value)
                    tbl_mark_value(cmd.value);
                if (cmd.last)
                    apply_match_marks(1'b0, 1'b0);
            end
            FN_READ: begin
                if (int'(cmd.index) < tbl_count) begin
                    r.found = 1'b1;
                    r.read_value = tbl_value[cmd.index];
                end else begin
                    r.status = ST_RANGE;
                end
            end
            default: ;
        endcase
        r.count = tbl_count[COUNT_W-1:0];
        r.empty_res = (tbl_count == 0);
        return r;
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic set_cmd_t make_cmd(logic [FUNC_W-1:0] f, logic [VALUE_W-1:0] v,
                                          logic [INDEX_W-1:0] idx, logic hv, logic lst);
        set_cmd_t c;
        c.func = f;
        c.value = v;
        c.index = idx;
        c.has_value = hv;
        c.last = lst;
        return c;
    endfunction

    // small values dominate so that hits and duplicates are common
    function automatic logic [VALUE_W-1:0] draw_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return $urandom;
            default: return $urandom_range(0, 5);
        endcase
    endfunction

    // called at a rising edge; returns at the edge that accepted the transaction
    task automatic send_cmd(input set_cmd_t cmd);
        int gap;
        gap = tx_no_idle ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(S_TDATA_W - VALUE_W - INDEX_W){1'b0}}, cmd.index, cmd.value};
        s_tuser <= {cmd.has_value, cmd.func};
        s_tlast <= cmd.last;
        do @(posedge aclk); while (!s_tready);
        pending_replies.push_back(predict_table_step(cmd));
    endtask

    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge aclk);
    endtask

    // ---------------- tests ----------------

    task automatic test_directed_cases();
        send_cmd(make_cmd(FN_READ, 32'h0, 4'd0, 1'b0, 1'b0));        // empty read
        send_cmd(make_cmd(FN_LOOKUP, 32'h0, 4'd0, 1'b0, 1'b0));
        send_cmd(make_cmd(FN_DELETE, 32'h0, 4'd0, 1'b0, 1'b0));
        send_cmd(make_cmd(FN_INTERSECT, 32'h0, 4'd0, 1'b0, 1'b1));   // empty other set
        send_cmd(make_cmd(FN_NOP, 32'hffff_ffff, 4'd15, 1'b1, 1'b1));
        send_cmd(make_cmd(FN_INSERT, 32'h8000_0000, 4'd0, 1'b1, 1'b0));
        send_cmd(make_cmd(FN_INSERT, 32'h7fff_ffff, 4'd0, 1'b1, 1'b0));
        send_cmd(make_cmd(FN_INSERT, 32'hffff_ffff, 4'd0, 1'b0, 1'b0));
        send_cmd(make_cmd(FN_INSERT, 32'h0, 4'd0, 1'b0, 1'b1));
        send_cmd(make_cmd(FN_INSERT, 32'h8000_0000, 4'd0, 1'b0, 1'b0));
        send_cmd(make_cmd(FN_LOOKUP, 32'h7fff_ffff, 4'd0, 1'b0, 1'b0));
        send_cmd(make_cmd(FN_READ, 32'h0, 4'd15, 1'b0, 1'b0));       // out of range
        send_cmd(make_cmd(FN_READ, 32'h0, 4'd4, 1'b0, 1'b0));
        send_cmd(make_cmd(FN_UNION, 32'h0, 4'd0, 1'b1, 1'b0));       // already present
        send_cmd(make_cmd(FN_UNION, 32'h5, 4'd0, 1'b0, 1'b1));       // no element
        send_cmd(make_cmd(FN_UNION, 32'h5, 4'd0, 1'b1, 1'b1));
        send_cmd(make_cmd(FN_DELETE, 32'h8000_0000, 4'd0, 1'b0, 1'b0));
        // marks must follow their entries through delete and stay clear on insert
        send_cmd(make_cmd(FN_DIFFERENCE, 32'hffff_ffff, 4'd0, 1'b1, 1'b0));
        send_cmd(make_cmd(FN_DELETE, 32'h0, 4'd0, 1'b0, 1'b0));
        send_cmd(make_cmd(FN_INSERT, 32'h9, 4'd0, 1'b0, 1'b0));
        send_cmd(make_cmd(FN_DIFFERENCE, 32'h0, 4'd0, 1'b0, 1'b1));
        // intersection keeps only the first copy
        send_cmd(make_cmd(FN_INSERT, 32'h7fff_ffff, 4'd0, 1'b0, 1'b0));
        send_cmd(make_cmd(FN_INTERSECT, 32'h7fff_ffff, 4'd0, 1'b1, 1'b0));
        send_cmd(make_cmd(FN_INTERSECT, 32'h9, 4'd0, 1'b1, 1'b1));
        send_cmd(make_cmd(FN_READ, 32'h0, 4'd1, 1'b0, 1'b0));
    endtask

    task automatic test_full_table();
        while (tbl_count < TABLE_DEPTH)
            send_cmd(make_cmd(FN_INSERT, draw_value(), 4'd0, 1'b0, 1'b0));
        send_cmd(make_cmd(FN_INSERT, 32'h1234_5678, 4'd0, 1'b0, 1'b0));     // dropped
        send_cmd(make_cmd(FN_UNION, 32'h5a5a_0001, 4'd0, 1'b1, 1'b0));      // dropped
        send_cmd(make_cmd(FN_UNION, tbl_value[3], 4'd0, 1'b1, 1'b1));       // present
        send_cmd(make_cmd(FN_READ, 32'h0, 4'd15, 1'b0, 1'b0));
        send_cmd(make_cmd(FN_INTERSECT, tbl_value[0], 4'd0, 1'b1, 1'b0));
        send_cmd(make_cmd(FN_INTERSECT, tbl_value[7], 4'd0, 1'b1, 1'b0));
        send_cmd(make_cmd(FN_INTERSECT, tbl_value[15], 4'd0, 1'b1, 1'b1));
    endtask

    // receiver holds off while the sender keeps offering back to back
    task automatic test_output_stall();
        int i;
        rx_hold_left = 300;
        tx_no_idle = 1'b1;
        for (i = 0; i < 14; i++)
            send_cmd(make_cmd(i % 2 ? FN_LOOKUP : FN_INSERT, draw_value(),
                              INDEX_W'($urandom), 1'b0, 1'b0));
        tx_no_idle = 1'b0;
    endtask

    task automatic test_random_traffic(input int n_items);
        int sent;
        int run_len;
        int i;
        logic [FUNC_W-1:0] set_fn;
        logic [FUNC_W-1:0] single_fn;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 15) == 0) begin
                tx_no_idle = ($urandom_range(0, 2) == 0);
                rx_no_idle = ($urandom_range(0, 2) == 0);
            end
            if ($urandom_range(0, 40) == 0)
                wait_for_drain();
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    case ($urandom_range(0, 19))
                        0, 1, 2, 3, 4, 5, 6: single_fn = FN_INSERT;
                        7, 8, 9:             single_fn = FN_DELETE;
                        10, 11, 12:          single_fn = FN_LOOKUP;
                        19:                  single_fn = FN_NOP;
                        default:             single_fn = FN_READ;
                    endcase
                    send_cmd(make_cmd(single_fn, draw_value(), INDEX_W'($urandom),
                                      1'($urandom), 1'($urandom)));
                    sent++;
                end
                4, 5, 6, 7: begin
                    // well-formed run of the other set
                    case ($urandom_range(0, 2))
                        0:       set_fn = FN_UNION;
                        1:       set_fn = FN_INTERSECT;
                        default: set_fn = FN_DIFFERENCE;
                    endcase
                    run_len = $urandom_range(0, 5);
                    if (run_len == 0) begin
                        send_cmd(make_cmd(set_fn, $urandom, INDEX_W'($urandom), 1'b0, 1'b1));
                        sent++;
                    end
                    for (i = 0; i < run_len; i++) begin
                        send_cmd(make_cmd(set_fn, draw_value(), INDEX_W'($urandom),
                                          ($urandom_range(0, 7) != 0), i == run_len - 1));
                        sent++;
                    end
                end
                8: begin
                    // noise: any code, any flags
                    send_cmd(make_cmd(FUNC_W'($urandom_range(0, 7)), $urandom,
                                      INDEX_W'($urandom), 1'($urandom), 1'($urandom)));
                    sent++;
                end
                default: begin
                    run_len = $urandom_range(4, 12);
                    for (i = 0; i < run_len; i++) begin
                        send_cmd(make_cmd(FN_INSERT, draw_value(), INDEX_W'($urandom),
                                          1'($urandom), 1'($urandom)));
                        sent++;
                    end
                end
            endcase
        end
    endtask

    // ---------------- result side ----------------

    always @(posedge aclk) begin
        if (rx_hold_left > 0) begin
            rx_hold_left = rx_hold_left - 1;
            m_tready <= 1'b0;
        end else if (m_tvalid && m_tready) begin
            rx_wait_left = rx_no_idle ? 0 : $urandom_range(0, 8);
            m_tready <= (rx_wait_left == 0);
        end else if (rx_wait_left > 0) begin
            rx_wait_left = rx_wait_left - 1;
            m_tready <= (rx_wait_left == 0);
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp_v, act_v);
            err_count++;
        end
    endtask

    always @(posedge aclk) begin
        set_reply_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_replies.size() == 0) begin
                $display("%0t: reply with none expected, actual tdata 0x%0h", $time, m_tdata);
                err_count++;
            end else begin
                want = pending_replies.pop_front();
                check_field("found", want.found, m_tdata[0]);
                check_field("read_value", want.read_value, m_tdata[32:1]);
                check_field("count", want.count, m_tdata[37:33]);
                check_field("empty_res", want.empty_res, m_tdata[38]);
                check_field("status", want.status, m_tdata[40:39]);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        aresetn = 1'b0;
        tbl_count = 0;
        tbl_mark = '0;
        err_count = 0;
        cycle_count = 0;
        rx_hold_left = 0;
        rx_wait_left = 0;
        tx_no_idle = 1'b0;
        rx_no_idle = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_cases();
        wait_for_drain();
        test_full_table();
        wait_for_drain();
        test_output_stall();
        wait_for_drain();
        test_random_traffic(1700);
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (err_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
